// ===== sv/dcb_pkg.sv =====
package dcb_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int CTX_W       = 7;
   localparam int COUNT_W     = 4;
   localparam int CHAN_W      = 2;
   localparam int BUCKET_W    = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTEXT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_COUNT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_COUNT       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_B_COUNT       = 2'd3;

   localparam logic [CHAN_W-1:0] CHAN_X = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_Y = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_B = 2'd2;

   localparam logic MODE_CLASSIFY = 1'b0;
   localparam logic MODE_LOAD     = 1'b1;

   typedef struct packed {
      logic               wr;
      logic [COUNT_W-1:0] index;
   } load_cmd_type;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n,
                                                      input logic [COUNT_W-1:0] limit);
      clamp_count = (n > limit) ? limit : n;
   endfunction

endpackage

// ===== sv/dcb_lane.sv =====
module dcb_lane #(
   parameter int MAX_THRESHOLDS = 15,
   parameter int VALUE_BITS     = 32,
   parameter int CNT_W          = 4
) (
   input  logic                                clock,
   input  logic                                enable,
   input  dcb_pkg::load_cmd_type               load,
   input  logic signed [VALUE_BITS-1:0]        load_value,
   input  logic signed [VALUE_BITS-1:0]        value,
   input  logic [dcb_pkg::COUNT_W-1:0]         count,
   output logic [CNT_W-1:0]                    hits_ff
);

   localparam int IDX_W = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
   localparam logic [dcb_pkg::COUNT_W-1:0] LIMIT = dcb_pkg::COUNT_W'(MAX_THRESHOLDS);

   logic signed [VALUE_BITS-1:0] bank_ff [MAX_THRESHOLDS];
   logic [dcb_pkg::COUNT_W-1:0]  n_used;
   logic [CNT_W-1:0]             hits_in;

   always_ff @(posedge clock) begin
      if (load.wr) begin
         bank_ff[load.index[IDX_W-1:0]] <= load_value;
      end
   end

   always_comb begin
      n_used  = dcb_pkg::clamp_count(count, LIMIT);
      hits_in = '0;
      for (int i = 0; i < MAX_THRESHOLDS; i++) begin
         if ((int'(n_used) > i) && (value > bank_ff[i])) begin
            hits_in = hits_in + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hits_ff <= hits_in;
      end
   end

endmodule

// ===== sv/dcb_merge.sv =====
module dcb_merge #(
   parameter int MAX_THRESHOLDS = 15,
   parameter int CNT_W          = 4
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [CNT_W-1:0]                    bx,
   input  logic [CNT_W-1:0]                    by,
   input  logic [CNT_W-1:0]                    bb,
   input  logic [dcb_pkg::COUNT_W-1:0]         ny_count,
   input  logic [dcb_pkg::COUNT_W-1:0]         nb_count,
   input  logic                                force_zero,
   output logic [dcb_pkg::BUCKET_W-1:0]        bucket_ff
);

   localparam int BW = dcb_pkg::BUCKET_W;
   localparam logic [dcb_pkg::COUNT_W-1:0] LIMIT = dcb_pkg::COUNT_W'(MAX_THRESHOLDS);

   logic [BW-1:0]    partial_ff;
   logic [BW-1:0]    partial_in;
   logic [CNT_W-1:0] by_ff;
   logic [BW-1:0]    nb_radix;
   logic [BW-1:0]    ny_radix;
   logic [BW-1:0]    bucket_in;

   always_comb begin
      nb_radix   = BW'(dcb_pkg::clamp_count(nb_count, LIMIT)) + BW'(1);
      ny_radix   = BW'(dcb_pkg::clamp_count(ny_count, LIMIT)) + BW'(1);
      partial_in = BW'(bx) * nb_radix + BW'(bb);
      bucket_in  = force_zero ? '0 : (partial_ff * ny_radix + BW'(by_ff));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         partial_ff <= partial_in;
         by_ff      <= by;
         bucket_ff  <= bucket_in;
      end
   end

endmodule

// ===== sv/dc_context_bucket_classifier.sv =====
// DC context bucket classifier.
// Request channel (req_valid/req_stall): mode 0 carries a pixel's x, y, b DC
// values and yields one rsp_bucket transfer; mode 1 writes one threshold entry
// (load_channel, load_index, load_value) and yields nothing.
// Config channel (csr_valid/csr_ready): writes context_count and the three
// threshold counts; csr_ready is always high. Write only while the block is idle.
// Three compare lanes (x, y, b) each test their value against each threshold
// in use (count clamped to MAX_THRESHOLDS) in parallel and count the hits; a
// two-stage merge forms the mixed-radix bucket, one multiply per stage; bucket
// is 0 if context_count <= 1. Registers: lane hits, merge partial, bucket.
// Throughput: one item per cycle unless stalled; a load followed directly by a
// pixel is fine. When rsp_stall holds a pending result the whole pipe freezes
// and req_stall is raised in the same cycle; nothing is dropped.
// Reset clears the pipe valid bits and sets context_count to 1 and the
// threshold counts to 0. The threshold table is not cleared: every entry in
// use must be loaded before pixels are sent.
module dc_context_bucket_classifier #(
   parameter int MAX_THRESHOLDS = 15,
   parameter int VALUE_BITS     = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [VALUE_BITS-1:0]           req_dc_x,
   input  logic signed [VALUE_BITS-1:0]           req_dc_y,
   input  logic signed [VALUE_BITS-1:0]           req_dc_b,
   input  logic [dcb_pkg::CHAN_W-1:0]             req_load_channel,
   input  logic [dcb_pkg::COUNT_W-1:0]            req_load_index,
   input  logic signed [VALUE_BITS-1:0]           req_load_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [dcb_pkg::BUCKET_W-1:0]           rsp_bucket,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dcb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [dcb_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int CNT_W = $clog2(MAX_THRESHOLDS + 1);

   logic                           pipe_en;
   logic                           req_xfer;
   logic                           idx_ok;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s2_valid_ff, s2_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dcb_pkg::CTX_W-1:0]      ctx_count_ff;
   logic [dcb_pkg::COUNT_W-1:0]    x_count_ff, y_count_ff, b_count_ff;
   dcb_pkg::load_cmd_type          load_x, load_y, load_b;
   logic [CNT_W-1:0]               hits_x, hits_y, hits_b;

   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign idx_ok = (int'(req_load_index) < MAX_THRESHOLDS);

   always_comb begin
      load_x.index = req_load_index;
      load_y.index = req_load_index;
      load_b.index = req_load_index;
      load_x.wr = req_xfer && (req_mode == dcb_pkg::MODE_LOAD) && idx_ok
                  && (req_load_channel == dcb_pkg::CHAN_X);
      load_y.wr = req_xfer && (req_mode == dcb_pkg::MODE_LOAD) && idx_ok
                  && (req_load_channel == dcb_pkg::CHAN_Y);
      load_b.wr = req_xfer && (req_mode == dcb_pkg::MODE_LOAD) && idx_ok
                  && (req_load_channel == dcb_pkg::CHAN_B);
   end

   always_comb begin
      s1_valid_in  = pipe_en ? (req_xfer && (req_mode == dcb_pkg::MODE_CLASSIFY))
                             : s1_valid_ff;
      s2_valid_in  = pipe_en ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = pipe_en ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_count_ff <= dcb_pkg::CTX_W'(1);
         x_count_ff   <= '0;
         y_count_ff   <= '0;
         b_count_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dcb_pkg::CSR_CONTEXT_COUNT: ctx_count_ff <= csr_data[dcb_pkg::CTX_W-1:0];
            dcb_pkg::CSR_X_COUNT:       x_count_ff   <= csr_data[dcb_pkg::COUNT_W-1:0];
            dcb_pkg::CSR_Y_COUNT:       y_count_ff   <= csr_data[dcb_pkg::COUNT_W-1:0];
            dcb_pkg::CSR_B_COUNT:       b_count_ff   <= csr_data[dcb_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   dcb_lane #(
      .MAX_THRESHOLDS(MAX_THRESHOLDS), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)
   ) u_lane_x (
      .clock(clock), .enable(pipe_en), .load(load_x), .load_value(req_load_value),
      .value(req_dc_x), .count(x_count_ff), .hits_ff(hits_x)
   );

   dcb_lane #(
      .MAX_THRESHOLDS(MAX_THRESHOLDS), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)
   ) u_lane_y (
      .clock(clock), .enable(pipe_en), .load(load_y), .load_value(req_load_value),
      .value(req_dc_y), .count(y_count_ff), .hits_ff(hits_y)
   );

   dcb_lane #(
      .MAX_THRESHOLDS(MAX_THRESHOLDS), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)
   ) u_lane_b (
      .clock(clock), .enable(pipe_en), .load(load_b), .load_value(req_load_value),
      .value(req_dc_b), .count(b_count_ff), .hits_ff(hits_b)
   );

   dcb_merge #(
      .MAX_THRESHOLDS(MAX_THRESHOLDS), .CNT_W(CNT_W)
   ) u_merge (
      .clock(clock), .enable(pipe_en), .bx(hits_x), .by(hits_y), .bb(hits_b),
      .ny_count(y_count_ff), .nb_count(b_count_ff),
      .force_zero(ctx_count_ff <= dcb_pkg::CTX_W'(1)), .bucket_ff(rsp_bucket)
   );

endmodule

// ===== tb/tb_dc_context_bucket_classifier.sv =====
module tb_dc_context_bucket_classifier;

   localparam int VALUE_BITS = 32;
   localparam int MAX_THR    = 15;
   localparam int PIPE_LAT   = 3;
   localparam int WATCHDOG   = 2000;
   localparam int PHASE_LEN  = 200;

   localparam logic [dcb_pkg::CHAN_W-1:0] CHAN_NONE = 2'd3;
   localparam logic [VALUE_BITS-1:0]      VMIN      = 32'h8000_0000;
   localparam logic [VALUE_BITS-1:0]      VMAX      = 32'h7FFF_FFFF;

   typedef struct {
      logic                          mode;
      logic signed [VALUE_BITS-1:0]  dc_x;
      logic signed [VALUE_BITS-1:0]  dc_y;
      logic signed [VALUE_BITS-1:0]  dc_b;
      logic [dcb_pkg::CHAN_W-1:0]    ch;
      logic [dcb_pkg::COUNT_W-1:0]   idx;
      logic signed [VALUE_BITS-1:0]  val;
   } req_item_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_mode = dcb_pkg::MODE_CLASSIFY;
   logic signed [VALUE_BITS-1:0]    req_dc_x = '0;
   logic signed [VALUE_BITS-1:0]    req_dc_y = '0;
   logic signed [VALUE_BITS-1:0]    req_dc_b = '0;
   logic [dcb_pkg::CHAN_W-1:0]      req_load_channel = dcb_pkg::CHAN_X;
   logic [dcb_pkg::COUNT_W-1:0]     req_load_index = '0;
   logic signed [VALUE_BITS-1:0]    req_load_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [dcb_pkg::BUCKET_W-1:0]    rsp_bucket;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dcb_pkg::CSR_INDEX_W-1:0] csr_index = dcb_pkg::CSR_CONTEXT_COUNT;
   logic [dcb_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   dc_context_bucket_classifier u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_dc_x         (req_dc_x),
      .req_dc_y         (req_dc_y),
      .req_dc_b         (req_dc_b),
      .req_load_channel (req_load_channel),
      .req_load_index   (req_load_index),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bucket       (rsp_bucket),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // shadow of the block state
   logic signed [VALUE_BITS-1:0] thr_mem [0:3*MAX_THR-1];
   logic [dcb_pkg::CTX_W-1:0]    ctx_cnt;
   logic [dcb_pkg::COUNT_W-1:0]  x_cnt, y_cnt, b_cnt;

   req_item_type                 req_queue [$];
   logic [dcb_pkg::BUCKET_W-1:0] bucket_queue [$];
   logic [dcb_pkg::BUCKET_W-1:0] want_bucket;
   req_item_type                 cur_item;
   bit                           req_taken = 1'b0;
   bit                           progress;
   int                           idle_cycles = 0;
   int                           errors = 0;
   int                           burst_left = 0;
   int                           gap_left = 0;
   int                           stall_mode = 0;
   int                           stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int count_hits(input int ch, input int n,
                                     input logic signed [VALUE_BITS-1:0] v);
      int hits;
      hits = 0;
      for (int i = 0; i < n; i++) begin
         if (v > thr_mem[ch*MAX_THR + i]) hits++;
      end
      return hits;
   endfunction

   function automatic logic [dcb_pkg::BUCKET_W-1:0] calc_bucket(
         input logic signed [VALUE_BITS-1:0] x, y, b);
      int          bx, by, bb;
      int unsigned mixed;
      if (ctx_cnt <= 1) return '0;
      bx = count_hits(dcb_pkg::CHAN_X, x_cnt, x);
      by = count_hits(dcb_pkg::CHAN_Y, y_cnt, y);
      bb = count_hits(dcb_pkg::CHAN_B, b_cnt, b);
      mixed = (bx * (b_cnt + 1) + bb) * (y_cnt + 1) + by;
      return mixed[dcb_pkg::BUCKET_W-1:0];
   endfunction

   // predictor and checker
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (reset) begin
         ctx_cnt = 7'd1;
         x_cnt = '0;
         y_cnt = '0;
         b_cnt = '0;
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            case (csr_index)
               dcb_pkg::CSR_CONTEXT_COUNT: ctx_cnt = csr_data[dcb_pkg::CTX_W-1:0];
               dcb_pkg::CSR_X_COUNT:       x_cnt = csr_data[dcb_pkg::COUNT_W-1:0];
               dcb_pkg::CSR_Y_COUNT:       y_cnt = csr_data[dcb_pkg::COUNT_W-1:0];
               dcb_pkg::CSR_B_COUNT:       b_cnt = csr_data[dcb_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            progress = 1'b1;
            if (req_mode == dcb_pkg::MODE_LOAD) begin
               if (req_load_channel != CHAN_NONE && req_load_index < MAX_THR)
                  thr_mem[req_load_channel*MAX_THR + req_load_index] = req_load_value;
            end else begin
               bucket_queue.push_back(calc_bucket(req_dc_x, req_dc_y, req_dc_b));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            if (bucket_queue.size() == 0) begin
               $error("rsp_bucket transfer with nothing pending: actual %0d", rsp_bucket);
               errors++;
            end else begin
               want_bucket = bucket_queue.pop_front();
               if (rsp_bucket !== want_bucket) begin
                  $error("rsp_bucket mismatch: expected %0d, actual %0d",
                         want_bucket, rsp_bucket);
                  errors++;
               end
            end
         end
         if (progress) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_queue.size() > 0) begin
            cur_item = req_queue.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= cur_item.mode;
            req_dc_x         <= cur_item.dc_x;
            req_dc_y         <= cur_item.dc_y;
            req_dc_b         <= cur_item.dc_b;
            req_load_channel <= cur_item.ch;
            req_load_index   <= cur_item.idx;
            req_load_value   <= cur_item.val;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 120);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 4) != 0);
         default: rsp_stall <= stall_left[1];
      endcase
   end

   function automatic logic signed [VALUE_BITS-1:0] rand_dc();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 2200)) - 1100;
         6, 7: return thr_mem[$urandom_range(0, 3*MAX_THR-1)];
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] rand_thr();
      case ($urandom_range(0, 9))
         0: return VMIN;
         1: return VMAX;
         2, 3: return $urandom;
         default: return int'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   task automatic push_pixel(input logic signed [VALUE_BITS-1:0] x, y, b);
      req_item_type it;
      it.mode = dcb_pkg::MODE_CLASSIFY;
      it.dc_x = x;
      it.dc_y = y;
      it.dc_b = b;
      it.ch = dcb_pkg::CHAN_W'($urandom);
      it.idx = dcb_pkg::COUNT_W'($urandom);
      it.val = $urandom;
      req_queue.push_back(it);
   endtask

   task automatic push_load(input logic [dcb_pkg::CHAN_W-1:0] ch,
                            input logic [dcb_pkg::COUNT_W-1:0] idx,
                            input logic signed [VALUE_BITS-1:0] v);
      req_item_type it;
      it.mode = dcb_pkg::MODE_LOAD;
      it.dc_x = $urandom;
      it.dc_y = $urandom;
      it.dc_b = $urandom;
      it.ch = ch;
      it.idx = idx;
      it.val = v;
      req_queue.push_back(it);
   endtask

   task automatic write_csr(input logic [dcb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [dcb_pkg::CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [dcb_pkg::CSR_DATA_W-1:0] ctx,
                             input logic [dcb_pkg::COUNT_W-1:0] nx, ny, nb);
      write_csr(dcb_pkg::CSR_CONTEXT_COUNT, ctx);
      write_csr(dcb_pkg::CSR_X_COUNT, {4'($urandom_range(0, 15)), nx});
      write_csr(dcb_pkg::CSR_Y_COUNT, {4'($urandom_range(0, 15)), ny});
      write_csr(dcb_pkg::CSR_B_COUNT, {4'($urandom_range(0, 15)), nb});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // loads give no result, so allow the pipe to drain past the last bucket
   task automatic wait_idle();
      while (req_queue.size() != 0 || req_valid || bucket_queue.size() != 0)
         @(posedge clock);
      repeat (PIPE_LAT + 3) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 3*MAX_THR; i++) thr_mem[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: everything lands in bucket 0
      push_pixel(VMIN, VMIN, VMIN);
      push_pixel(VMAX, VMAX, VMAX);
      push_pixel(VMIN, VMAX, -1);
      push_load(CHAN_NONE, 4'd3, VMAX);
      push_load(dcb_pkg::CHAN_X, 4'd15, VMIN);
      push_load(dcb_pkg::CHAN_B, 4'd15, VMAX);

      // fill every threshold before any compare uses it
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < MAX_THR; i++) begin
            if (c == dcb_pkg::CHAN_X && i == 0)
               push_load(dcb_pkg::CHAN_W'(c), dcb_pkg::COUNT_W'(i), VMIN);
            else if (c == dcb_pkg::CHAN_Y && i == MAX_THR-1)
               push_load(dcb_pkg::CHAN_W'(c), dcb_pkg::COUNT_W'(i), VMAX);
            else if (c == dcb_pkg::CHAN_B && i == 7)
               push_load(dcb_pkg::CHAN_W'(c), dcb_pkg::COUNT_W'(i), '0);
            else
               push_load(dcb_pkg::CHAN_W'(c), dcb_pkg::COUNT_W'(i),
                         int'($urandom_range(0, 2000)) - 1000);
         end
      end
      wait_idle();

      set_config(8'd2, 4'd0, 4'd0, 4'd0);
      push_pixel(VMAX, VMAX, VMAX);
      push_pixel(VMIN, 0, VMAX);
      wait_idle();

      set_config(8'd64, 4'd15, 4'd15, 4'd15);
      push_pixel(VMAX, VMAX, VMAX);
      push_pixel(VMIN, VMIN, VMIN);
      push_pixel(thr_mem[0], thr_mem[MAX_THR], thr_mem[2*MAX_THR]);
      push_pixel(thr_mem[1], thr_mem[2*MAX_THR-1], thr_mem[2*MAX_THR+7]);
      push_pixel(thr_mem[1] + 1, thr_mem[MAX_THR+3] - 1, 1);
      push_load(dcb_pkg::CHAN_X, 4'd14, VMAX);
      push_pixel(VMAX, 0, 0);
      push_load(dcb_pkg::CHAN_B, 4'd0, VMIN);
      push_pixel(0, 0, VMIN + 1);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p)
            0: set_config(8'h80, 4'd15, 4'd15, 4'd15);
            1: set_config(8'd1, 4'd0, 4'd0, 4'd0);
            2: set_config(8'd2, 4'd15, 4'd0, 4'd1);
            3: set_config(8'd64, 4'd15, 4'd15, 4'd15);
            4: set_config(8'hFF, 4'd15, 4'd15, 4'd15);
            default: set_config(8'($urandom_range(2, 255)), 4'($urandom),
                                4'($urandom), 4'($urandom));
         endcase
         for (int k = 0; k < PHASE_LEN; k++) begin
            if ($urandom_range(0, 6) == 0)
               push_load(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_thr());
            else
               push_pixel(rand_dc(), rand_dc(), rand_dc());
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (bucket_queue.size() != 0) begin
         $error("%0d rsp_bucket transfers never arrived", bucket_queue.size());
         errors++;
      end
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
